// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define STG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define STG_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define STG_ASSERT(lbl, prop, msg)
`define STG_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== hw/rtl/stg_pkg.sv =====
// ----------------------------------------------------------------------------
// Sine tone generator package
// Command codes, queue entry types and fixed constants of the tone generator.
// ----------------------------------------------------------------------------
package stg_pkg;

  // Command code carried by each input item.
  typedef enum logic {
    CMD_NOTE = 1'b0,
    CMD_TICK = 1'b1
  } stg_cmd_e;

  // Depth of the command queue between front and back; a power of two.
  localparam int QUEUE_DEPTH = 4;

  // Gain register value after reset: one quarter (0.25) in unsigned Q1.15.
  localparam logic [15:0] GAIN_RESET = 16'd8192;

  // Classification of one queued command.
  typedef struct packed {
    logic tick;
    logic rest;
    logic zero_len;
  } stg_kind_t;

  // Head of the command queue as seen by the back end.
  typedef struct packed {
    logic      valid;
    stg_kind_t kind;
  } stg_head_t;

  // Control tag that travels with a sample through the back-end stages.
  typedef struct packed {
    logic valid;
    logic last;
    logic active;
    logic neg;
  } stg_tag_t;

endpackage

// ===== hw/rtl/sine_tone_generator_with_fade.sv =====
// ----------------------------------------------------------------------------
// Sine tone generator with fade
// DDS sine oscillator with linear fade-in and fade-out and a programmable gain.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  command   in         push / full               cmd_i, phase_step_i, note_length_i,
//                                                 is_rest_i
//  sample    out        empty / pop               sample_o, last_of_note_o, note_active_o
//  gain      in         cfg_valid / cfg_ready     amplitude_gain_i
//
//  One command per cycle is taken sustained while output samples are taken; a
//  tick is written into the queue, handed to the first of six back-end registers
//  and carried through the rest to the result ports. The back-end pipeline
//  freezes while the output register holds an untaken sample; the four-entry
//  command queue keeps accepting until it fills. Reset sets the gain to 8192
//  and the oscillator to idle; no clearing pass. The gain register is always
//  ready; the user must write it only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module sine_tone_generator_with_fade import stg_pkg::*; #(
  parameter int FADE_SAMPLES    = 200,
  parameter int LENGTH_BITS     = 24,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               cmd_i,
  input  logic [31:0]        phase_step_i,
  input  logic [23:0]        note_length_i,
  input  logic               is_rest_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] sample_o,
  output logic               last_of_note_o,
  output logic               note_active_o,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        amplitude_gain_i
);

  logic [15:0]            gain_q;
  stg_head_t              head;
  logic [31:0]            head_step;
  logic [LENGTH_BITS-1:0] head_len;
  logic                   queue_pop;

  // Gain register, written on each configuration transfer.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gain_q <= amplitude_gain_i;
    end
  end

  // Front end: command intake and queue.
  stg_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .cmd_i         (cmd_i),
    .phase_step_i  (phase_step_i),
    .note_length_i (note_length_i),
    .is_rest_i     (is_rest_i),
    .pop_i         (queue_pop),
    .head_o        (head),
    .head_step_o   (head_step),
    .head_len_o    (head_len)
  );

  // Back end: oscillator and sample pipeline.
  stg_back #(
    .FADE_SAMPLES    (FADE_SAMPLES),
    .LENGTH_BITS     (LENGTH_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .head_step_i    (head_step),
    .head_len_i     (head_len),
    .pop_o          (queue_pop),
    .gain_i         (gain_q),
    .pop_i          (pop),
    .empty_o        (empty),
    .sample_o       (sample_o),
    .last_of_note_o (last_of_note_o),
    .note_active_o  (note_active_o)
  );

endmodule

// ===== hw/rtl/stg_front.sv =====
// ----------------------------------------------------------------------------
// Tone generator front end
// Accepts commands, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stg_front import stg_pkg::*; #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  output logic                   full_o,
  input  logic                   cmd_i,
  input  logic [31:0]            phase_step_i,
  input  logic [23:0]            note_length_i,
  input  logic                   is_rest_i,
  input  logic                   pop_i,
  output stg_head_t              head_o,
  output logic [31:0]            head_step_o,
  output logic [LENGTH_BITS-1:0] head_len_o
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [31:0]            step_mem [QUEUE_DEPTH];
  logic [LENGTH_BITS-1:0] len_mem  [QUEUE_DEPTH];
  stg_kind_t              kind_mem [QUEUE_DEPTH];

  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  logic                   push_ok;
  logic [LENGTH_BITS-1:0] len_in;
  stg_kind_t              kind_in;

  // Only the low length bits are kept; a zero length is flagged here.
  always_comb begin
    push_ok          = push_i && !full_o;
    len_in           = LENGTH_BITS'(note_length_i);
    kind_in.tick     = (cmd_i == CMD_TICK);
    kind_in.rest     = is_rest_i;
    kind_in.zero_len = (len_in == '0);
  end

  assign full_o = (count_q == CntW'(QUEUE_DEPTH));

  // Queue storage, written on each accepted transfer.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      step_mem[wr_ptr_q] <= phase_step_i;
      len_mem[wr_ptr_q]  <= len_in;
      kind_mem[wr_ptr_q] <= kind_in;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(push_ok) - CntW'(pop_i);
    end
  end

  // Head of the queue.
  always_comb begin
    head_o.valid = (count_q != '0);
    head_o.kind  = kind_mem[rd_ptr_q];
    head_step_o  = step_mem[rd_ptr_q];
    head_len_o   = len_mem[rd_ptr_q];
  end

  `STG_ASSERT(a_count_bound, count_q <= CntW'(QUEUE_DEPTH), "queue count exceeds depth")
  `STG_ASSERT_NEVER(a_pop_empty, pop_i && (count_q == '0), "queue popped while empty")

endmodule

// ===== hw/rtl/stg_back.sv =====
// ----------------------------------------------------------------------------
// Tone generator back end
// Runs the oscillator state and the six-stage sample pipeline, whose last stage is the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stg_back import stg_pkg::*; #(
  parameter int FADE_SAMPLES    = 200,
  parameter int LENGTH_BITS     = 24,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stg_head_t              head_i,
  input  logic [31:0]            head_step_i,
  input  logic [LENGTH_BITS-1:0] head_len_i,
  output logic                   pop_o,
  input  logic [15:0]            gain_i,
  input  logic                   pop_i,
  output logic                   empty_o,
  output logic signed [15:0]     sample_o,
  output logic                   last_of_note_o,
  output logic                   note_active_o
);

  // Quarter-wave table geometry.
  localparam int Quarter = 2 ** (SINE_TABLE_BITS - 2);
  localparam int QaW     = SINE_TABLE_BITS - 1;
  localparam int RW      = SINE_TABLE_BITS - 2;

  // Datapath widths.
  localparam int WW    = $clog2(FADE_SAMPLES + 1);
  localparam int M2W   = 15 + WW;
  localparam int M3W   = M2W + 16;
  localparam int YRawW = M3W - 15;
  localparam int Clamp = 32769 * FADE_SAMPLES;
  localparam int YW    = $clog2(Clamp + 1);
  localparam int MW    = YW + 1;
  localparam int PW    = YW + MW;
  localparam int QfW   = 16 + WW;

  localparam int Stages = 6;

  // Reciprocal of the fade length; exact to within one for every clamped value.
  localparam logic [MW-1:0] Recip = MW'((64'd1 << YW) / FADE_SAMPLES);
  localparam logic [WW-1:0] FadeW = WW'(FADE_SAMPLES);

  // Fixed-point constants of the table build.
  localparam logic [63:0] HalfPiQ30   = 64'd1686629713;
  localparam logic [63:0] Q30One      = 64'd1 << 30;
  localparam int          TaylorTerms = 6;

  typedef logic [14:0] rom_word_t;
  typedef rom_word_t rom_t [Quarter + 1];

  // One Horner step divisor of the sine series, innermost term first.
  function automatic logic [63:0] taylor_div(input int n, input logic [63:0] v);
    logic [63:0] r;
    case (n)
      0:       r = v / 64'd156;
      1:       r = v / 64'd110;
      2:       r = v / 64'd72;
      3:       r = v / 64'd42;
      4:       r = v / 64'd20;
      default: r = v / 64'd6;
    endcase
    return r;
  endfunction

  // Quarter-wave sine magnitudes, built at elaboration from the Taylor series.
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] x, x2, t, d, s;
    for (int a = 0; a <= Quarter; a++) begin
      x  = (64'(a) * HalfPiQ30) >> RW;
      x2 = (x * x) >> 30;
      t  = Q30One;
      for (int n = 0; n < TaylorTerms; n++) begin
        d = taylor_div(n, (x2 * t) >> 30);
        t = (d >= Q30One) ? 64'd0 : Q30One - d;
      end
      s      = (x * t) >> 30;
      rom[a] = 15'((s * 64'd32767 + (64'd1 << 29)) >> 30);
    end
    return rom;
  endfunction

  localparam rom_t SineRom = build_rom();

  // Oscillator state.
  logic [31:0]            phase_q, inc_q;
  logic [LENGTH_BITS-1:0] idx_q, len_q;
  logic                   rest_q, active_q;

  // Pipeline registers.
  stg_tag_t          tag_q [Stages];
  rom_word_t         rom_q;
  logic [WW-1:0]     w1_q;
  logic [M2W-1:0]    m2_q;
  logic [M3W-1:0]    m3_q;
  logic [YW-1:0]     y4_q, y5_q, qf5_q;
  logic [PW-1:0]     p4_q;
  logic [15:0]       q5_q;
  logic signed [15:0] sample_q;

  logic                   adv;
  logic [LENGTH_BITS-1:0] remain;
  logic                   is_last;
  logic [WW-1:0]          w0;
  logic [SINE_TABLE_BITS-1:0] addr;
  logic [QaW-1:0]         qaddr;
  stg_tag_t               tag0;
  logic [YRawW-1:0]       yraw;
  logic [YW-1:0]          yc;
  logic [15:0]            q0;
  logic [YW-1:0]          rem;
  logic [15:0]            q6;
  logic signed [15:0]     sample_d;

  // The whole pipeline moves unless the output register holds an untaken sample.
  assign adv   = !tag_q[Stages-1].valid || pop_i;
  assign pop_o = adv && head_i.valid;

  // Issue stage: fade weight, table address and end-of-note detection.
  always_comb begin
    remain  = len_q - idx_q;
    is_last = (remain == LENGTH_BITS'(1));
    if (32'(idx_q) < 32'(FADE_SAMPLES)) begin
      w0 = WW'(idx_q);
    end else if (32'(remain) < 32'(FADE_SAMPLES)) begin
      w0 = WW'(remain);
    end else begin
      w0 = FadeW;
    end
    if (rest_q || !active_q) begin
      w0 = '0;
    end
    addr = phase_q[31 -: SINE_TABLE_BITS];
    if (addr[RW]) begin
      qaddr = QaW'(Quarter) - QaW'(addr[RW-1:0]);
    end else begin
      qaddr = QaW'(addr[RW-1:0]);
    end
    tag0.valid  = head_i.valid && head_i.kind.tick;
    tag0.last   = active_q && is_last;
    tag0.active = active_q;
    tag0.neg    = addr[SINE_TABLE_BITS-1];
  end

  // Oscillator state update on each command taken from the queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      inc_q    <= '0;
      idx_q    <= '0;
      len_q    <= '0;
      rest_q   <= 1'b0;
      active_q <= 1'b0;
    end else if (pop_o) begin
      if (!head_i.kind.tick) begin
        phase_q  <= '0;
        inc_q    <= head_step_i;
        idx_q    <= '0;
        len_q    <= head_len_i;
        rest_q   <= head_i.kind.rest;
        active_q <= !head_i.kind.zero_len;
      end else if (active_q) begin
        phase_q <= phase_q + inc_q;
        idx_q   <= idx_q + LENGTH_BITS'(1);
        if (is_last) begin
          active_q <= 1'b0;
        end
      end
    end
  end

  // Tags shift along with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Stages; k++) begin
        tag_q[k] <= '0;
      end
    end else if (adv) begin
      tag_q[0] <= tag0;
      for (int k = 1; k < Stages; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  // Clamp before the division so the quotient stays within 16 bits.
  always_comb begin
    yraw = m3_q[M3W-1:15];
    if (yraw >= YRawW'(Clamp)) begin
      yc = YW'(Clamp);
    end else begin
      yc = YW'(yraw);
    end
    q0 = 16'(p4_q >> YW);
  end

  // Quotient correction, sign and saturation.
  always_comb begin
    rem = y5_q - qf5_q;
    q6  = q5_q + 16'(rem >= YW'(FADE_SAMPLES));
    if (tag_q[4].neg) begin
      sample_d = (q6 > 16'd32768) ? -16'sd32768 : signed'(16'(-q6));
    end else begin
      sample_d = (q6 > 16'd32767) ? 16'sd32767 : signed'(q6);
    end
  end

  // Datapath stages: table read, weight, gain, reciprocal, correction, output.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rom_q    <= SineRom[qaddr];
      w1_q     <= w0;
      m2_q     <= M2W'(rom_q) * M2W'(w1_q);
      m3_q     <= M3W'(m2_q) * M3W'(gain_i);
      y4_q     <= yc;
      p4_q     <= PW'(yc) * PW'(Recip);
      y5_q     <= y4_q;
      q5_q     <= q0;
      qf5_q    <= YW'(QfW'(q0) * QfW'(FADE_SAMPLES));
      sample_q <= sample_d;
    end
  end

  assign empty_o        = !tag_q[Stages-1].valid;
  assign sample_o       = sample_q;
  assign last_of_note_o = tag_q[Stages-1].last;
  assign note_active_o  = tag_q[Stages-1].active;

  `STG_ASSERT(a_idx_range, active_q |-> (idx_q < len_q), "sample index ran past the note length")
  `STG_ASSERT(a_last_ends, (pop_o && head_i.kind.tick && active_q && is_last) |=> !active_q,
              "note still active after its last sample")
  `STG_ASSERT(a_recip_err, tag_q[4].valid |-> (rem < YW'(2 * FADE_SAMPLES)),
              "reciprocal quotient estimate off by more than one")
  `STG_ASSERT(a_idle_zero, (tag_q[Stages-1].valid && !tag_q[Stages-1].active) |-> (sample_q == '0),
              "idle tick produced a nonzero sample")

endmodule
